>>> src/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types and constants for the buddy block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

    localparam int ORD_W  = 6;
    localparam int TV_W   = 5;
    localparam int CALC_W = 33;
    localparam int SIZE_W = 17;
    localparam int OFF_W  = 16;
    localparam int STAT_W = 2;

    typedef enum logic [1:0] {
        MODE_ALLOC,
        MODE_FREE,
        MODE_REALLOC,
        MODE_REINIT
    } bba_mode_t;

    localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NOSPACE = 2'd1;
    localparam logic [STAT_W-1:0] STAT_BADOFF  = 2'd2;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_FF_ROOT,
        S_FF_CHECK,
        S_FF_STEP,
        S_FF_DATA,
        S_FU_STEP,
        S_FU_DATA,
        S_MU_START,
        S_MF_START,
        S_UP_STEP,
        S_UP_DATA,
        S_DONE
    } bba_state_t;

    typedef struct packed {
        logic accept;
        logic clr_write;
        logic rd_root;
        logic ff_init;
        logic ff_read;
        logic ff_step;
        logic fu_read;
        logic fu_next;
        logic set_nospace;
        logic set_badoff;
        logic mu_start;
        logic mf_start;
        logic up_read;
        logic up_write;
        logic out_load;
    } bba_cmd_t;

    typedef struct packed {
        bba_mode_t in_mode;
        bba_mode_t mode;
        logic      clr_last;
        logic      size_bad;
        logic      root_short;
        logic      ff_at_ord;
        logic      fu_bad;
        logic      rd_zero;
        logic      same_ord;
        logic      up_at_root;
        logic      out_free;
    } bba_stat_t;

endpackage

>>> src/buddy_block_allocator.sv
// ----------------------------------------------------------------------------
// buddy_block_allocator
// Binary buddy allocator over a free-order tree held in one RAM.
// ----------------------------------------------------------------------------
// Each search and each update walk takes a read state and a step state per
// tree level, through one RAM read port. One request at a time.
// Reset and reinitialize run a sweep over all 2^(POOL_ORDER-MIN_ORDER+1)-1
// nodes (2047 by default) writing every node; no request is taken meanwhile.
module buddy_block_allocator
    import bba_pkg::*;
#(
    parameter int POOL_ORDER = 16,
    parameter int MIN_ORDER  = 6
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_mode,
    input  logic [SIZE_W-1:0] s_req_size,
    input  logic [OFF_W-1:0]  s_block_offset,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [STAT_W-1:0] m_status,
    output logic [OFF_W-1:0]  m_result_offset,
    output logic [4:0]        m_granted_order,
    output logic [SIZE_W-1:0] m_copy_length
);

    bba_cmd_t  cmd;
    bba_stat_t stat;

    bba_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    bba_dp #(
        .POOL_ORDER (POOL_ORDER),
        .MIN_ORDER  (MIN_ORDER)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .stat            (stat),
        .s_mode          (s_mode),
        .s_req_size      (s_req_size),
        .s_block_offset  (s_block_offset),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_result_offset (m_result_offset),
        .m_granted_order (m_granted_order),
        .m_copy_length   (m_copy_length)
    );

endmodule

>>> src/bba_ram.sv
// ----------------------------------------------------------------------------
// bba_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bba_ram #(
    parameter int WIDTH = 5,
    parameter int DEPTH = 2047
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> src/bba_ctrl.sv
// ----------------------------------------------------------------------------
// bba_ctrl
// Sequencer: clearing sweep, free search, used search and tree update walks.
// ----------------------------------------------------------------------------
module bba_ctrl
    import bba_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  bba_stat_t stat,
    output bba_cmd_t  cmd
);

    bba_state_t state_reg, state_next;
    logic       free_pend_reg, free_pend_next;
    logic       clr_reply_reg, clr_reply_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            free_pend_reg <= 1'b0;
            clr_reply_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            free_pend_reg <= free_pend_next;
            clr_reply_reg <= clr_reply_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        free_pend_next = free_pend_reg;
        clr_reply_next = clr_reply_reg;
        case (state_reg)
            S_CLEAR: begin
                if (stat.clr_last) begin
                    state_next = clr_reply_reg ? S_DONE : S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    case (stat.in_mode)
                        MODE_REINIT: begin
                            state_next     = S_CLEAR;
                            clr_reply_next = 1'b1;
                        end
                        MODE_ALLOC: state_next = S_FF_ROOT;
                        default:    state_next = S_FU_STEP;
                    endcase
                end
            end
            S_FF_ROOT:  state_next = S_FF_CHECK;
            S_FF_CHECK: begin
                state_next = (stat.size_bad || stat.root_short) ? S_DONE : S_FF_STEP;
            end
            S_FF_STEP: begin
                if (stat.ff_at_ord) begin
                    if (stat.mode == MODE_REALLOC && stat.same_ord) begin
                        state_next = S_DONE;
                    end else begin
                        state_next     = S_MU_START;
                        free_pend_next = (stat.mode == MODE_REALLOC);
                    end
                end else begin
                    state_next = S_FF_DATA;
                end
            end
            S_FF_DATA: state_next = S_FF_STEP;
            S_FU_STEP: state_next = stat.fu_bad ? S_DONE : S_FU_DATA;
            S_FU_DATA: begin
                if (stat.rd_zero) begin
                    state_next = (stat.mode == MODE_FREE) ? S_MF_START : S_FF_ROOT;
                end else begin
                    state_next = S_FU_STEP;
                end
            end
            S_MU_START: state_next = S_UP_STEP;
            S_MF_START: begin
                state_next     = S_UP_STEP;
                free_pend_next = 1'b0;
            end
            S_UP_STEP: begin
                if (stat.up_at_root) begin
                    state_next = free_pend_reg ? S_MF_START : S_DONE;
                end else begin
                    state_next = S_UP_DATA;
                end
            end
            S_UP_DATA: state_next = S_UP_STEP;
            S_DONE: begin
                if (stat.out_free) begin
                    state_next     = S_IDLE;
                    clr_reply_next = 1'b0;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            S_CLEAR: cmd.clr_write = 1'b1;
            S_IDLE: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
            end
            S_FF_ROOT:  cmd.rd_root = 1'b1;
            S_FF_CHECK: begin
                if (stat.size_bad || stat.root_short) begin
                    cmd.set_nospace = 1'b1;
                end else begin
                    cmd.ff_init = 1'b1;
                end
            end
            S_FF_STEP:  cmd.ff_read = !stat.ff_at_ord;
            S_FF_DATA:  cmd.ff_step = 1'b1;
            S_FU_STEP: begin
                if (stat.fu_bad) begin
                    cmd.set_badoff = 1'b1;
                end else begin
                    cmd.fu_read = 1'b1;
                end
            end
            S_FU_DATA:  cmd.fu_next = !stat.rd_zero;
            S_MU_START: cmd.mu_start = 1'b1;
            S_MF_START: cmd.mf_start = 1'b1;
            S_UP_STEP:  cmd.up_read = !stat.up_at_root;
            S_UP_DATA:  cmd.up_write = 1'b1;
            S_DONE:     cmd.out_load = stat.out_free;
            default:    cmd = '0;
        endcase
    end

    a_pend_realloc: assert property (@(posedge aclk) disable iff (!aresetn)
        free_pend_reg |-> stat.mode == MODE_REALLOC)
        else $error("pending free outside reallocate");

    a_accept_leaves: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.accept |=> state_reg != S_IDLE)
        else $error("accepted request left controller idle");

endmodule

>>> src/bba_dp.sv
// ----------------------------------------------------------------------------
// bba_dp
// Datapath: request registers, tree RAM, walk pointers and result register.
// ----------------------------------------------------------------------------
module bba_dp
    import bba_pkg::*;
#(
    parameter int POOL_ORDER = 16,
    parameter int MIN_ORDER  = 6
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  bba_cmd_t          cmd,
    output bba_stat_t         stat,
    input  logic [1:0]        s_mode,
    input  logic [SIZE_W-1:0] s_req_size,
    input  logic [OFF_W-1:0]  s_block_offset,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [STAT_W-1:0] m_status,
    output logic [OFF_W-1:0]  m_result_offset,
    output logic [4:0]        m_granted_order,
    output logic [SIZE_W-1:0] m_copy_length
);

    localparam int IW    = POOL_ORDER - MIN_ORDER + 1;
    localparam int NODES = (1 << IW) - 1;

    localparam logic [ORD_W-1:0]  P_ORD = ORD_W'(POOL_ORDER);
    localparam logic [ORD_W-1:0]  M_ORD = ORD_W'(MIN_ORDER);
    localparam logic [CALC_W-1:0] POOL_BYTES = CALC_W'(1) << POOL_ORDER;

    bba_mode_t         mode_reg;
    logic              size_zero_reg;
    logic [ORD_W-1:0]  req_ord_reg;
    logic [OFF_W-1:0]  off_reg;
    logic [STAT_W-1:0] status_reg;
    logic [IW-1:0]     ff_idx_reg;
    logic [ORD_W-1:0]  ff_lvl_reg;
    logic [ORD_W-1:0]  fu_ord_reg;
    logic [IW-1:0]     up_idx_reg;
    logic [TV_W-1:0]   up_val_reg;
    logic [TV_W-1:0]   up_co_reg;
    logic [IW-1:0]     sw_idx_reg;
    logic [TV_W-1:0]   sw_ord_reg;
    logic [IW-1:0]     sw_last_reg;
    logic              m_valid_reg;
    logic [STAT_W-1:0] m_status_reg;
    logic [OFF_W-1:0]  m_offset_reg;
    logic [4:0]        m_order_reg;
    logic [SIZE_W-1:0] m_copy_reg;

    logic [SIZE_W-1:0] size_m1;
    logic [ORD_W-1:0]  size_blen;
    logic [ORD_W-1:0]  size_ord;
    logic [IW-1:0]     ff_left;
    logic [CALC_W-1:0] off_ext;
    logic [CALC_W-1:0] fu_calc;
    logic [IW-1:0]     fu_idx;
    logic [OFF_W-1:0]  align_mask;
    logic [IW-1:0]     up_sib;
    logic [IW-1:0]     up_parent;
    logic [TV_W-1:0]   up_pv;
    logic [CALC_W-1:0] node_off_calc;
    logic [ORD_W-1:0]  copy_ord;
    logic [CALC_W-1:0] copy_calc;
    logic              rd_en;
    logic [IW-1:0]     rd_addr;
    logic [TV_W-1:0]   rd_data;
    logic              wr_en;
    logic [IW-1:0]     wr_addr;
    logic [TV_W-1:0]   wr_data;

    always_comb begin
        size_m1   = s_req_size - SIZE_W'(1);
        size_blen = '0;
        for (int i = 0; i < SIZE_W; i++) begin
            if (size_m1[i]) begin
                size_blen = ORD_W'(i + 1);
            end
        end
        size_ord = (size_blen < M_ORD) ? M_ORD : size_blen;
    end

    assign ff_left = (ff_idx_reg << 1) | IW'(1);

    assign off_ext = CALC_W'(off_reg);
    assign fu_calc = ((POOL_BYTES + off_ext) >> fu_ord_reg) - CALC_W'(1);
    assign fu_idx  = fu_calc[IW-1:0];

    always_comb begin
        for (int i = 0; i < OFF_W; i++) begin
            align_mask[i] = (ORD_W'(i) < fu_ord_reg);
        end
    end

    assign up_sib    = up_idx_reg[0] ? up_idx_reg + IW'(1) : up_idx_reg - IW'(1);
    assign up_parent = (up_idx_reg - IW'(1)) >> 1;

    always_comb begin
        if (up_val_reg == up_co_reg && rd_data == up_co_reg) begin
            up_pv = up_co_reg + TV_W'(1);
        end else begin
            up_pv = (up_val_reg > rd_data) ? up_val_reg : rd_data;
        end
    end

    assign node_off_calc = ((CALC_W'(ff_idx_reg) + CALC_W'(1)) << req_ord_reg) - POOL_BYTES;
    assign copy_ord      = (req_ord_reg < fu_ord_reg) ? req_ord_reg : fu_ord_reg;
    assign copy_calc     = CALC_W'(1) << copy_ord;

    always_comb begin
        rd_en   = cmd.rd_root | cmd.ff_read | cmd.fu_read | cmd.up_read;
        rd_addr = '0;
        if (cmd.ff_read) begin
            rd_addr = ff_left;
        end else if (cmd.fu_read) begin
            rd_addr = fu_idx;
        end else if (cmd.up_read) begin
            rd_addr = up_sib;
        end
    end

    always_comb begin
        wr_en   = cmd.clr_write | cmd.mu_start | cmd.mf_start | cmd.up_write;
        wr_addr = sw_idx_reg;
        wr_data = sw_ord_reg;
        if (cmd.mu_start) begin
            wr_addr = ff_idx_reg;
            wr_data = '0;
        end else if (cmd.mf_start) begin
            wr_addr = fu_idx;
            wr_data = fu_ord_reg[TV_W-1:0];
        end else if (cmd.up_write) begin
            wr_addr = up_parent;
            wr_data = up_pv;
        end
    end

    bba_ram #(
        .WIDTH (TV_W),
        .DEPTH (NODES)
    ) u_tree (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sw_idx_reg  <= '0;
            sw_ord_reg  <= TV_W'(POOL_ORDER);
            sw_last_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.clr_write && !stat.clr_last) begin
                sw_idx_reg <= sw_idx_reg + IW'(1);
                if (sw_idx_reg == sw_last_reg) begin
                    sw_ord_reg  <= sw_ord_reg - TV_W'(1);
                    sw_last_reg <= (sw_last_reg << 1) + IW'(2);
                end
            end else begin
                sw_idx_reg  <= '0;
                sw_ord_reg  <= TV_W'(POOL_ORDER);
                sw_last_reg <= '0;
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            mode_reg      <= bba_mode_t'(s_mode);
            size_zero_reg <= (s_req_size == '0);
            req_ord_reg   <= size_ord;
            off_reg       <= s_block_offset;
            status_reg    <= STAT_OK;
            fu_ord_reg    <= M_ORD;
        end
        if (cmd.set_nospace) begin
            status_reg <= STAT_NOSPACE;
        end
        if (cmd.set_badoff) begin
            status_reg <= STAT_BADOFF;
        end
        if (cmd.ff_init) begin
            ff_idx_reg <= '0;
            ff_lvl_reg <= P_ORD;
        end
        if (cmd.ff_step) begin
            ff_idx_reg <= (ORD_W'(rd_data) >= req_ord_reg) ? ff_left : ff_left + IW'(1);
            ff_lvl_reg <= ff_lvl_reg - ORD_W'(1);
        end
        if (cmd.fu_next) begin
            fu_ord_reg <= fu_ord_reg + ORD_W'(1);
        end
        if (cmd.mu_start) begin
            up_idx_reg <= ff_idx_reg;
            up_val_reg <= '0;
            up_co_reg  <= req_ord_reg[TV_W-1:0];
        end
        if (cmd.mf_start) begin
            up_idx_reg <= fu_idx;
            up_val_reg <= fu_ord_reg[TV_W-1:0];
            up_co_reg  <= fu_ord_reg[TV_W-1:0];
        end
        if (cmd.up_write) begin
            up_idx_reg <= up_parent;
            up_val_reg <= up_pv;
            up_co_reg  <= up_co_reg + TV_W'(1);
        end
        if (cmd.out_load) begin
            m_status_reg <= status_reg;
            m_offset_reg <= '0;
            m_order_reg  <= '0;
            m_copy_reg   <= '0;
            if (status_reg == STAT_OK) begin
                case (mode_reg)
                    MODE_ALLOC: begin
                        m_offset_reg <= node_off_calc[OFF_W-1:0];
                        m_order_reg  <= req_ord_reg[4:0];
                    end
                    MODE_REALLOC: begin
                        if (req_ord_reg == fu_ord_reg) begin
                            m_offset_reg <= off_reg;
                            m_order_reg  <= fu_ord_reg[4:0];
                        end else begin
                            m_offset_reg <= node_off_calc[OFF_W-1:0];
                            m_order_reg  <= req_ord_reg[4:0];
                            m_copy_reg   <= copy_calc[SIZE_W-1:0];
                        end
                    end
                    default: m_offset_reg <= '0;
                endcase
            end
        end
    end

    always_comb begin
        stat            = '0;
        stat.in_mode    = bba_mode_t'(s_mode);
        stat.mode       = mode_reg;
        stat.clr_last   = (sw_idx_reg == IW'(NODES - 1));
        stat.size_bad   = size_zero_reg || (req_ord_reg > P_ORD);
        stat.root_short = (req_ord_reg > ORD_W'(rd_data));
        stat.ff_at_ord  = (ff_lvl_reg == req_ord_reg);
        stat.fu_bad     = (off_ext >= POOL_BYTES) || (fu_ord_reg > P_ORD)
                          || ((off_reg & align_mask) != '0);
        stat.rd_zero    = (rd_data == '0);
        stat.same_ord   = (req_ord_reg == fu_ord_reg);
        stat.up_at_root = (up_idx_reg == '0);
        stat.out_free   = !m_valid_reg || m_ready;
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_result_offset = m_offset_reg;
    assign m_granted_order = m_order_reg;
    assign m_copy_length   = m_copy_reg;

    a_descend_above: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.ff_step |-> ff_lvl_reg > req_ord_reg)
        else $error("descent below requested order");

    a_up_not_root: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.up_write |-> up_idx_reg != '0)
        else $error("update walk past root");

    a_mark_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.mu_start || cmd.mf_start) |-> status_reg == STAT_OK)
        else $error("tree update on failed request");

endmodule
